FILE: design/utf8_code_point_decoder_top_assert.svh
// Assertion helpers for the decoder modules; utf8_front includes them.
`ifndef UTF8_CODE_POINT_DECODER_TOP_ASSERT_SVH
`define UTF8_CODE_POINT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define UTF8_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UTF8_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/utf8_pkg.sv
`timescale 1ns / 1ps
package utf8_pkg;

   localparam int QueueDepth = 4;

   localparam logic [2:0] StOk      = 3'd0;
   localparam logic [2:0] StNul     = 3'd1;
   localparam logic [2:0] StBadCont = 3'd2;
   localparam logic [2:0] StBadLead = 3'd3;
   localparam logic [2:0] StTrunc   = 3'd4;

   localparam logic [2:0] ExpIdle = 3'd0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } utf8_req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic [2:0]  status;
      logic        run_last;
   } utf8_rsp_type;

   // Results of one byte: first, and optionally a second.
   typedef struct packed {
      logic         two;
      utf8_rsp_type first;
      utf8_rsp_type second;
   } utf8_entry_type;

   typedef struct packed {
      logic         emit;
      utf8_rsp_type rsp;
      logic [2:0]   exp;
      logic [20:0]  acc;
   } utf8_lead_type;

   function automatic utf8_rsp_type make_rsp(logic [20:0] cp, logic [2:0] cnt,
                                             logic [2:0] st);
      utf8_rsp_type r;
      r.code_point = cp;
      r.byte_count = cnt;
      r.status     = st;
      r.run_last   = 1'b0;
      return r;
   endfunction

   function automatic utf8_lead_type lead_decode(logic [7:0] b, logic eot);
      utf8_lead_type l;
      l.emit = 1'b0;
      l.rsp  = make_rsp(21'd0, 3'd1, StOk);
      l.exp  = ExpIdle;
      l.acc  = 21'd0;
      if (b == 8'd0) begin
         l.emit = 1'b1;
         l.rsp  = make_rsp(21'd0, 3'd1, StNul);
      end else if (!b[7]) begin
         l.emit = 1'b1;
         l.rsp  = make_rsp({13'd0, b}, 3'd1, StOk);
      end else if (b[7:5] == 3'b110) begin
         l.exp = 3'd2;
         l.acc = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         l.exp = 3'd3;
         l.acc = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         l.exp = 3'd4;
         l.acc = {18'd0, b[2:0]};
      end else begin
         l.emit = 1'b1;
         l.rsp  = make_rsp(21'd0, 3'd1, StBadLead);
      end
      if (l.exp != ExpIdle && eot) begin
         l.emit = 1'b1;
         l.rsp  = make_rsp(21'd0, 3'd1, StTrunc);
         l.exp  = ExpIdle;
         l.acc  = 21'd0;
      end
      return l;
   endfunction

endpackage

FILE: design/utf8_front.sv
`timescale 1ns / 1ps
module utf8_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  utf8_pkg::utf8_req_type  req_data,
   input  logic                    q_full,
   output logic                    q_push,
   output utf8_pkg::utf8_entry_type q_entry
);
   import utf8_pkg::*;

   logic [2:0]    exp_ff, exp_in;
   logic [2:0]    seen_ff, seen_in;
   logic [20:0]   acc_ff, acc_in;
   logic          accept;
   logic          has_res;
   logic [20:0]   acc_shift;
   logic [2:0]    seen_inc;
   utf8_lead_type lead;

   assign accept = req_push && !q_full;
   assign q_push = accept && has_res;

   always_comb begin
      lead      = lead_decode(req_data.data_byte, req_data.end_of_text);
      acc_shift = {acc_ff[14:0], req_data.data_byte[5:0]};
      seen_inc  = seen_ff + 3'd1;
      exp_in    = exp_ff;
      seen_in   = seen_ff;
      acc_in    = acc_ff;
      has_res   = 1'b0;
      q_entry   = '0;
      if (exp_ff == ExpIdle) begin
         has_res                = lead.emit;
         q_entry.first          = lead.rsp;
         q_entry.first.run_last = 1'b1;
         exp_in                 = lead.exp;
         seen_in                = (lead.exp != ExpIdle) ? 3'd1 : 3'd0;
         acc_in                 = lead.acc;
      end else if (req_data.data_byte[7:6] == 2'b10) begin
         acc_in  = acc_shift;
         seen_in = seen_inc;
         if (seen_inc >= exp_ff) begin
            has_res                = 1'b1;
            q_entry.first          = make_rsp(acc_shift, exp_ff, StOk);
            q_entry.first.run_last = 1'b1;
            exp_in                 = ExpIdle;
            seen_in                = 3'd0;
            acc_in                 = 21'd0;
         end else if (req_data.end_of_text) begin
            has_res                = 1'b1;
            q_entry.first          = make_rsp(21'd0, 3'd1, StTrunc);
            q_entry.first.run_last = 1'b1;
            exp_in                 = ExpIdle;
            seen_in                = 3'd0;
            acc_in                 = 21'd0;
         end
      end else begin
         // bad continuation, then the byte is taken again as a lead
         has_res                 = 1'b1;
         q_entry.first           = make_rsp(21'd0, 3'd1, StBadCont);
         q_entry.first.run_last  = !lead.emit;
         q_entry.two             = lead.emit;
         q_entry.second          = lead.rsp;
         q_entry.second.run_last = 1'b1;
         exp_in                  = lead.exp;
         seen_in                 = (lead.exp != ExpIdle) ? 3'd1 : 3'd0;
         acc_in                  = lead.acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= ExpIdle;
         seen_ff <= 3'd0;
         acc_ff  <= 21'd0;
      end else if (accept) begin
         exp_ff  <= exp_in;
         seen_ff <= seen_in;
         acc_ff  <= acc_in;
      end
   end

`include "utf8_code_point_decoder_top_assert.svh"
   `UTF8_ASSERT_NOW(a_idle_clear, exp_ff == ExpIdle, seen_ff == 3'd0 && acc_ff == 21'd0, "idle state not clear")
   `UTF8_ASSERT_NOW(a_seq_range, exp_ff != ExpIdle, seen_ff != 3'd0 && seen_ff < exp_ff && exp_ff <= 3'd4, "sequence counters out of range")
   `UTF8_ASSERT_NOW(a_one_last, q_push && !q_entry.two, q_entry.first.run_last, "single result lacks run_last")
   `UTF8_ASSERT_NOW(a_two_last, q_push && q_entry.two, !q_entry.first.run_last && q_entry.second.run_last && q_entry.first.status == StBadCont, "pair result malformed")
   `UTF8_ASSERT_NEXT(a_trunc_idle, accept && req_data.end_of_text, exp_ff == ExpIdle, "end of text left a sequence open")

endmodule

FILE: design/utf8_fifo.sv
`timescale 1ns / 1ps
module utf8_fifo #(
   parameter int DEPTH = utf8_pkg::QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  utf8_pkg::utf8_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output utf8_pkg::utf8_entry_type head_entry,
   output logic                     empty
);
   import utf8_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   utf8_entry_type  mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = count_ff == CntW'(DEPTH);
   assign empty      = count_ff == '0;
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
      end
   end

endmodule

FILE: design/utf8_back.sv
`timescale 1ns / 1ps
module utf8_back (
   input  logic                     clock,
   input  logic                     reset,
   input  utf8_pkg::utf8_entry_type head_entry,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output utf8_pkg::utf8_rsp_type   rsp_data
);
   import utf8_pkg::*;

   logic         out_valid_ff, out_valid_in;
   utf8_rsp_type out_ff, out_in;
   logic         sec_valid_ff, sec_valid_in;
   utf8_rsp_type sec_ff, sec_in;
   logic         advance;

   assign advance   = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      sec_valid_in = sec_valid_ff;
      sec_in       = sec_ff;
      q_pop        = 1'b0;
      if (advance) begin
         if (sec_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = sec_ff;
            sec_valid_in = 1'b0;
         end else if (!q_empty) begin
            out_valid_in = 1'b1;
            out_in       = head_entry.first;
            sec_valid_in = head_entry.two;
            sec_in       = head_entry.second;
            q_pop        = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sec_ff <= sec_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

endmodule

FILE: design/utf8_code_point_decoder_top.sv
// A byte's first result passes through the queue and then the output register to rsp_data.
// Throughput: one byte per cycle while the queue is not full; the output register drains
// one result per cycle while pop is high, so a byte with two results fills it twice in turn.
// The queue between decoder and output holds the results of up to QUEUE_DEPTH bytes during output stall.
// Reset is synchronous and active high: decode state, queue count and output valid flags all clear at once.
`timescale 1ns / 1ps
module utf8_code_point_decoder_top #(
   parameter int QUEUE_DEPTH = utf8_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  utf8_pkg::utf8_req_type req_data,
   output logic                   empty,
   input  logic                   pop,
   output utf8_pkg::utf8_rsp_type rsp_data
);
   import utf8_pkg::*;

   logic           q_push, q_full, q_pop, q_empty;
   utf8_entry_type q_entry, head_entry;

   assign full = q_full;

   utf8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   utf8_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty)
   );

   utf8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_empty  (empty),
      .rsp_pop    (pop),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: dv/utf8_decode_checker.sv
`timescale 1ns / 1ps
module utf8_decode_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  utf8_pkg::utf8_req_type req_data,
   input  logic                   empty,
   input  logic                   pop,
   input  utf8_pkg::utf8_rsp_type rsp_data,
   output int                     mismatch_total,
   output int                     owed_count
);
   import utf8_pkg::*;

   logic [2:0]   seq_len;
   logic [2:0]   seq_seen;
   logic [20:0]  partial_cp;
   utf8_rsp_type owed_chars[$];
   utf8_rsp_type fresh[$];
   int           bad_seen = 0;

   task automatic note(input logic [20:0] cp, input logic [2:0] cnt, input logic [2:0] st);
      utf8_rsp_type r;
      r.code_point = cp;
      r.byte_count = cnt;
      r.status     = st;
      r.run_last   = 1'b0;
      fresh.push_back(r);
   endtask

   task automatic drop_char();
      seq_len    = ExpIdle;
      seq_seen   = 3'd0;
      partial_cp = 21'd0;
   endtask

   task automatic start_char(input logic [7:0] b, input logic eot);
      if (b == 8'h00) begin
         note(21'd0, 3'd1, StNul);
      end else if (!b[7]) begin
         note({13'd0, b}, 3'd1, StOk);
      end else if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
         note(21'd0, 3'd1, StBadLead);
      end else begin
         if (!b[5]) begin
            seq_len    = 3'd2;
            partial_cp = {16'd0, b[4:0]};
         end else if (!b[4]) begin
            seq_len    = 3'd3;
            partial_cp = {17'd0, b[3:0]};
         end else begin
            seq_len    = 3'd4;
            partial_cp = {18'd0, b[2:0]};
         end
         seq_seen = 3'd1;
         if (eot) begin
            drop_char();
            note(21'd0, 3'd1, StTrunc);
         end
      end
   endtask

   task automatic absorb_byte(input utf8_req_type item);
      fresh.delete();
      if (seq_len == ExpIdle) begin
         start_char(item.data_byte, item.end_of_text);
      end else if (item.data_byte[7:6] == 2'b10) begin
         partial_cp = {partial_cp[14:0], item.data_byte[5:0]};
         seq_seen   = seq_seen + 3'd1;
         if (seq_seen >= seq_len) begin
            note(partial_cp, seq_len, StOk);
            drop_char();
         end else if (item.end_of_text) begin
            note(21'd0, 3'd1, StTrunc);
            drop_char();
         end
      end else begin
         // broken sequence: report it, then the byte starts over as a lead
         note(21'd0, 3'd1, StBadCont);
         drop_char();
         start_char(item.data_byte, item.end_of_text);
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].run_last = 1'b1;
      foreach (fresh[i]) owed_chars.push_back(fresh[i]);
   endtask

   task automatic check_char(input utf8_rsp_type got);
      utf8_rsp_type want;
      if (owed_chars.size() == 0) begin
         if (bad_seen < 10) begin
            $display("%0t: unexpected result cp=%h cnt=%0d st=%0d last=%0b", $time,
                     got.code_point, got.byte_count, got.status, got.run_last);
         end
         bad_seen++;
      end else begin
         want = owed_chars.pop_front();
         if (got.code_point !== want.code_point || got.byte_count !== want.byte_count ||
             got.status !== want.status || got.run_last !== want.run_last) begin
            if (bad_seen < 10) begin
               $display("%0t: mismatch exp cp=%h cnt=%0d st=%0d last=%0b,",
                        $time, want.code_point, want.byte_count, want.status,
                        want.run_last);
               $display("   got cp=%h cnt=%0d st=%0d last=%0b",
                        got.code_point, got.byte_count, got.status, got.run_last);
            end
            bad_seen++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         drop_char();
         owed_chars.delete();
      end else begin
         if (pop && !empty) check_char(rsp_data);
         if (push && !full) absorb_byte(req_data);
      end
      mismatch_total <= bad_seen;
      owed_count     <= owed_chars.size();
   end

endmodule

FILE: dv/tb_utf8_code_point_decoder_top.sv
`timescale 1ns / 1ps
module tb_utf8_code_point_decoder_top;
   import utf8_pkg::*;

   localparam int StallLimit = 4000;
   localparam int TotalBytes = 1550;
   localparam int HoldRound  = 30;
   localparam int HoldCycles = 400;

   // {end_of_text, data_byte}
   localparam logic [8:0] OpeningText [0:25] = '{
      9'h000, 9'h17F, 9'h0C2, 9'h0A9, 9'h0EF, 9'h0BF, 9'h0BF,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF, 9'h0F8,
      9'h0E2, 9'h0C3, 9'h0A9, 9'h0C2, 9'h0FF, 9'h0E2, 9'h182,
      9'h1F0, 9'h0C2, 9'h1C3, 9'h0C2, 9'h000
   };

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         push     = 1'b0;
   logic         pop      = 1'b0;
   utf8_req_type req_data = '0;
   logic         full;
   logic         empty;
   utf8_rsp_type rsp_data;
   int           mismatch_total;
   int           owed_count;
   int           quiet_cycles = 0;
   int           sent_bytes   = 0;

   utf8_code_point_decoder_top DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   utf8_decode_checker watch (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_data       (rsp_data),
      .mismatch_total (mismatch_total),
      .owed_count     (owed_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] char_byte(input int len, input int pos);
      if (pos > 0) return {2'b10, 6'($urandom)};
      case (len)
         1: return 8'($urandom_range(0, 127));
         2: return {3'b110, 5'($urandom)};
         3: return {4'b1110, 4'($urandom)};
         default: return {5'b11110, 3'($urandom)};
      endcase
   endfunction

   task automatic offer(input logic [7:0] b, input logic eot, input bit paced);
      int gap;
      gap = paced ? idle_len() : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push               <= 1'b1;
      req_data.data_byte   <= b;
      req_data.end_of_text <= eot;
      do @(posedge clock); while (full);
      sent_bytes++;
   endtask

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: random pop runs and gaps, one long hold to back the block up
   initial begin : drain
      int run_len;
      int gap;
      int round_no;
      round_no = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
         pop <= 1'b1;
         repeat (run_len) @(posedge clock);
         gap = (round_no == HoldRound) ? HoldCycles : idle_len();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         round_no++;
      end
   end

   initial begin : stimulus
      int  pick;
      int  len;
      int  cut;
      bit  paced;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OpeningText[i]) offer(OpeningText[i][7:0], OpeningText[i][8], 1'b1);

      while (sent_bytes < TotalBytes) begin
         paced = ((sent_bytes / 150) % 4) != 2;
         pick  = $urandom_range(0, 99);
         if (pick < 8) begin
            offer(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0, paced);
         end else begin
            len = $urandom_range(1, 4);
            // some sequences are cut short so the next lead breaks them
            cut = (pick < 16) ? $urandom_range(1, len) : len;
            for (int k = 0; k < cut; k++) begin
               offer(char_byte(len, k), $urandom_range(0, 24) == 0, paced);
            end
         end
      end
      push <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_total == 0 && owed_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
